>>> src/pfa_pkg.sv
// shared types, constants and helpers of the partition fit allocator
`default_nettype none
package pfa_pkg;

	// table geometry
	localparam int NUM_PARTS = 16;
	localparam int SIZE_BITS = 16;
	localparam int PART_BITS = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
	localparam int CMP_BITS  = (SIZE_BITS > 16) ? SIZE_BITS : 16;
	localparam logic [PART_BITS-1:0] PART_LAST = PART_BITS'(NUM_PARTS - 1);

	// command codes
	localparam logic [1:0] FN_LOAD    = 2'd0;
	localparam logic [1:0] FN_ALLOC   = 2'd1;
	localparam logic [1:0] FN_RECLAIM = 2'd2;
	localparam logic [1:0] FN_REWIND  = 2'd3;

	// fit policy codes
	localparam logic [1:0] POL_FIRST = 2'd0;
	localparam logic [1:0] POL_NEXT  = 2'd1;
	localparam logic [1:0] POL_BEST  = 2'd2;
	localparam logic [1:0] POL_WORST = 2'd3;

	// input transaction
	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  part_index;
		logic [15:0] amount;
		logic [15:0] base_in;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic        granted;
		logic [3:0]  chosen_part;
		logic [15:0] left_after;
		logic [15:0] chosen_base;
	} res_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_WRITE,
		ST_RECLAIM,
		ST_REPLY
	} state_t;

	// table write kinds
	typedef enum logic [1:0] {
		WR_LOAD,
		WR_TAKE,
		WR_RESTORE
	} wr_op_t;

	// table write request
	typedef struct packed {
		logic                 en;
		wr_op_t               op;
		logic [PART_BITS-1:0] addr;
		logic [SIZE_BITS-1:0] size;
		logic [SIZE_BITS-1:0] base;
	} tbl_wr_t;

	// operands of the shared compare unit
	typedef struct packed {
		logic [SIZE_BITS-1:0] a;
		logic [15:0]          req;
		logic [SIZE_BITS-1:0] best;
	} cmp_op_t;

	// flags and difference from the shared compare unit
	typedef struct packed {
		logic                 fit;
		logic                 less;
		logic                 more;
		logic [SIZE_BITS-1:0] diff;
	} cmp_res_t;

	// circular partition increment
	function automatic logic [PART_BITS-1:0] wrap_inc(input logic [PART_BITS-1:0] p);
		return (p == PART_LAST) ? '0 : p + PART_BITS'(1);
	endfunction

endpackage
`default_nettype wire

>>> src/pfa_table.sv
// partition table: original size, remaining size and base of every partition
`default_nettype none
module pfa_table (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [pfa_pkg::PART_BITS-1:0] rd_addr,
	input  wire pfa_pkg::tbl_wr_t              wr,
	output logic [pfa_pkg::SIZE_BITS-1:0]      rd_rest,
	output logic [pfa_pkg::SIZE_BITS-1:0]      rd_base
);
	import pfa_pkg::*;

	logic [SIZE_BITS-1:0] orig_q [NUM_PARTS];
	logic [SIZE_BITS-1:0] rest_q [NUM_PARTS];
	logic [SIZE_BITS-1:0] base_q [NUM_PARTS];

	// single read port at the probe address, or at the chosen partition while writing
	assign rd_rest = rest_q[rd_addr];
	assign rd_base = base_q[rd_addr];

	// entry updates, all cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PARTS; i++) begin
				orig_q[i] <= '0;
				rest_q[i] <= '0;
				base_q[i] <= '0;
			end
		end else if (wr.en) begin
			case (wr.op)
				WR_LOAD: begin
					orig_q[wr.addr] <= wr.size;
					rest_q[wr.addr] <= wr.size;
					base_q[wr.addr] <= wr.base;
				end
				WR_TAKE: begin
					rest_q[wr.addr] <= wr.size;
				end
				WR_RESTORE: begin
					rest_q[wr.addr] <= orig_q[wr.addr];
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

>>> src/pfa_cmp.sv
// shared compare and subtract unit used for every probe and the grant
`default_nettype none
module pfa_cmp (
	input  wire pfa_pkg::cmp_op_t op,
	output pfa_pkg::cmp_res_t     res
);
	import pfa_pkg::*;

	logic [CMP_BITS:0] diff_w;

	// a minus request with borrow, request compared at full width
	assign diff_w   = {1'b0, CMP_BITS'(op.a)} - {1'b0, CMP_BITS'(op.req)};
	assign res.fit  = !diff_w[CMP_BITS];
	assign res.diff = diff_w[SIZE_BITS-1:0];

	// ordering against the current candidate
	assign res.less = op.a < op.best;
	assign res.more = op.a > op.best;

endmodule
`default_nettype wire

>>> src/pfa_ctrl.sv
// sequencer: command decode, table scan, grant write-back, reclaim and result register
`default_nettype none
module pfa_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire pfa_pkg::cmd_t                 cmd,
	output logic                               busy,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [1:0]                    cfg_data,
	input  wire logic [pfa_pkg::SIZE_BITS-1:0] rd_rest,
	input  wire logic [pfa_pkg::SIZE_BITS-1:0] rd_base,
	output logic [pfa_pkg::PART_BITS-1:0]      rd_addr,
	output pfa_pkg::tbl_wr_t                   wr,
	output pfa_pkg::cmp_op_t                   cmp_op,
	input  wire pfa_pkg::cmp_res_t             cmp,
	output logic                               done,
	output pfa_pkg::res_t                      result
);
	import pfa_pkg::*;

	state_t               state_q, state_d;
	logic [1:0]           policy_q;
	logic [PART_BITS-1:0] rove_q;
	logic [PART_BITS-1:0] k_q;
	logic [PART_BITS-1:0] cnt_q;
	logic                 found_q;
	logic [PART_BITS-1:0] pick_q;
	logic [SIZE_BITS-1:0] pick_rest_q;
	cmd_t                 cmd_q;
	res_t                 res_q;

	logic accept;
	logic last;
	logic take;
	logic grant;

	// next state and control outputs
	always_comb begin
		state_d    = state_q;
		busy       = (state_q != ST_IDLE);
		accept     = start && !busy;
		last       = (cnt_q == PART_LAST);
		take       = 1'b0;
		wr         = '0;
		wr.op      = WR_LOAD;
		done       = (state_q == ST_REPLY);
		rd_addr    = (state_q == ST_WRITE) ? pick_q : k_q;
		cmp_op.a    = (state_q == ST_WRITE) ? pick_rest_q : rd_rest;
		cmp_op.req  = cmd_q.amount;
		cmp_op.best = pick_rest_q;
		grant      = found_q && cmp.fit;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FN_LOAD:    state_d = ST_WRITE;
						FN_ALLOC:   state_d = ST_SCAN;
						FN_RECLAIM: state_d = ST_RECLAIM;
						default:    state_d = ST_REPLY;
					endcase
				end
			end
			ST_SCAN: begin
				case (policy_q) inside
					POL_FIRST, POL_NEXT: begin
						take = cmp.fit;
						if (cmp.fit || last) state_d = ST_WRITE;
					end
					POL_BEST: begin
						take = cmp.fit && (!found_q || cmp.less);
						if (last) state_d = ST_WRITE;
					end
					default: begin
						take = !found_q || cmp.more;
						if (last) state_d = ST_WRITE;
					end
				endcase
			end
			ST_WRITE: begin
				if (cmd_q.func == FN_LOAD) begin
					wr.en   = (32'(cmd_q.part_index) < NUM_PARTS);
					wr.op   = WR_LOAD;
					wr.addr = PART_BITS'(cmd_q.part_index);
					wr.size = SIZE_BITS'(cmd_q.amount);
					wr.base = SIZE_BITS'(cmd_q.base_in);
				end else begin
					wr.en   = grant;
					wr.op   = WR_TAKE;
					wr.addr = pick_q;
					wr.size = cmp.diff;
				end
				state_d = ST_REPLY;
			end
			ST_RECLAIM: begin
				wr.en   = 1'b1;
				wr.op   = WR_RESTORE;
				wr.addr = k_q;
				if (last) state_d = ST_REPLY;
			end
			ST_REPLY: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// register writes only between transactions, never beside a starting command
	assign cfg_ready = !busy && !start;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// policy, roving pointer and scan counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= POL_FIRST;
			rove_q   <= '0;
			k_q      <= '0;
			cnt_q    <= '0;
			found_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) policy_q <= cfg_data;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q   <= '0;
						found_q <= 1'b0;
						k_q     <= (cmd.func == FN_ALLOC && policy_q == POL_NEXT) ? rove_q : '0;
						if (cmd.func == FN_RECLAIM || cmd.func == FN_REWIND) rove_q <= '0;
					end
				end
				ST_SCAN: begin
					if (take) found_q <= 1'b1;
					k_q   <= wrap_inc(k_q);
					cnt_q <= cnt_q + PART_BITS'(1);
				end
				ST_RECLAIM: begin
					k_q   <= wrap_inc(k_q);
					cnt_q <= cnt_q + PART_BITS'(1);
				end
				ST_WRITE: begin
					if (cmd_q.func == FN_ALLOC && grant && policy_q == POL_NEXT)
						rove_q <= wrap_inc(pick_q);
				end
				default: begin
				end
			endcase
		end
	end

	// command, candidate and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			res_q <= '0;
		end
		if (state_q == ST_SCAN && take) begin
			pick_q      <= k_q;
			pick_rest_q <= rd_rest;
		end
		if (state_q == ST_WRITE && cmd_q.func == FN_ALLOC && grant) begin
			res_q.granted     <= 1'b1;
			res_q.chosen_part <= 4'(pick_q);
			res_q.left_after  <= 16'(cmp.diff);
			res_q.chosen_base <= 16'(rd_base);
		end
	end

	assign result = res_q;

`ifndef ASSERT_OFF
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted transaction did not raise busy");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block still busy after its result");
	a_take_fits: assert property (@(posedge clk) disable iff (!arst_n)
		(wr.en && wr.op == WR_TAKE) |-> (found_q && cmp.fit))
		else $error("grant written without a fitting candidate");
	a_first_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && policy_q == POL_FIRST) |-> (k_q == cnt_q))
		else $error("first fit probe out of order");
`endif

endmodule
`default_nettype wire

>>> src/partition_fit_allocator.sv
// top level of the partition fit allocator
//
// One command is taken when start is high and busy is low; done is high for exactly one
// cycle with its result on result, and the receiver cannot stall it. One compare and
// subtract unit probes one table entry per cycle. Reclaim restores one entry per cycle,
// allocate under best or worst fit probes every entry, and allocate under first or next
// fit stops at the first entry that fits, or after all entries when none fits. The table
// is cleared at reset. The policy register is written through cfg_valid/cfg_ready, which
// accepts only while busy is low and no command is being started.
`default_nettype none
module partition_fit_allocator (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire pfa_pkg::cmd_t cmd,
	output logic               busy,
	input  wire logic          cfg_valid,
	output logic               cfg_ready,
	input  wire logic [1:0]    cfg_data,
	output logic               done,
	output pfa_pkg::res_t      result
);
	import pfa_pkg::*;

	logic [PART_BITS-1:0] rd_addr;
	logic [SIZE_BITS-1:0] rd_rest;
	logic [SIZE_BITS-1:0] rd_base;
	tbl_wr_t              wr;
	cmp_op_t              cmp_op;
	cmp_res_t             cmp;

	// sequencer
	pfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.rd_rest   (rd_rest),
		.rd_base   (rd_base),
		.rd_addr   (rd_addr),
		.wr        (wr),
		.cmp_op    (cmp_op),
		.cmp       (cmp),
		.done      (done),
		.result    (result)
	);

	// shared compare unit
	pfa_cmp u_cmp (
		.op  (cmp_op),
		.res (cmp)
	);

	// partition table
	pfa_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.wr      (wr),
		.rd_rest (rd_rest),
		.rd_base (rd_base)
	);

endmodule
`default_nettype wire
